// ----- rtl/core/dlt_pkg.sv -----
package dlt_pkg;

    localparam int MAX_LINE = 4096;
    localparam int IDX_W    = $clog2(MAX_LINE + 1);
    localparam int MAX_RES  = 3;

    // DFA states
    localparam logic [4:0] S_START   = 5'd0;
    localparam logic [4:0] S_SYMBOL  = 5'd1;
    localparam logic [4:0] S_ID      = 5'd2;
    localparam logic [4:0] S_NUM     = 5'd3;
    localparam logic [4:0] S_NUMDEC  = 5'd4;
    localparam logic [4:0] S_SQ      = 5'd5;
    localparam logic [4:0] S_SQESC   = 5'd6;
    localparam logic [4:0] S_DQ      = 5'd7;
    localparam logic [4:0] S_DQESC   = 5'd8;
    localparam logic [4:0] S_STREND  = 5'd9;
    localparam logic [4:0] S_WS      = 5'd10;
    localparam logic [4:0] S_COMMENT = 5'd11;
    localparam logic [4:0] S_LT      = 5'd12;
    localparam logic [4:0] S_STAR1   = 5'd13;
    localparam logic [4:0] S_STAR2   = 5'd14;
    localparam logic [4:0] S_EQSIG   = 5'd15;
    localparam logic [4:0] S_OP      = 5'd16;
    localparam logic [4:0] NS_ERR    = 5'd30;
    localparam logic [4:0] NS_HARD   = 5'd31;

    // token types
    localparam logic [4:0] T_SYMBOL   = 5'd0;
    localparam logic [4:0] T_ID       = 5'd1;
    localparam logic [4:0] T_NUM      = 5'd2;
    localparam logic [4:0] T_STRING   = 5'd3;
    localparam logic [4:0] T_PLUS     = 5'd4;
    localparam logic [4:0] T_MINUS    = 5'd5;
    localparam logic [4:0] T_STAR     = 5'd6;
    localparam logic [4:0] T_STARSTAR = 5'd7;
    localparam logic [4:0] T_SLASH    = 5'd8;
    localparam logic [4:0] T_PERCENT  = 5'd9;
    localparam logic [4:0] T_LPAREN   = 5'd10;
    localparam logic [4:0] T_RPAREN   = 5'd11;
    localparam logic [4:0] T_LBRACE   = 5'd12;
    localparam logic [4:0] T_RBRACE   = 5'd13;
    localparam logic [4:0] T_LBRACK   = 5'd14;
    localparam logic [4:0] T_RBRACK   = 5'd15;
    localparam logic [4:0] T_SEMI     = 5'd16;
    localparam logic [4:0] T_COMMA    = 5'd17;
    localparam logic [4:0] T_EQUALS   = 5'd18;
    localparam logic [4:0] T_EQSIGNAL = 5'd19;
    localparam logic [4:0] T_DROP     = 5'd20;
    localparam logic [4:0] T_NONE     = 5'd21;

    // result kinds
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // characters
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic [4:0]       st;
        logic [4:0]       held;
        logic [IDX_W-1:0] lstart;
        logic [IDX_W-1:0] bidx;
        logic             failed;
        logic [IDX_W-1:0] eidx;
    } lex_state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [4:0]       token_type;
        logic [15:0]      token_line;
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] length;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] r;
        logic [1:0]         cnt;
    } pkt_t;

    localparam lex_state_t LEX_RESET = '{st: S_START, held: 5'd0, lstart: '0,
                                         bidx: '0, failed: 1'b0, eidx: '0};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [4:0] op_type(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            8'h2B:   t = T_PLUS;
            8'h2D:   t = T_MINUS;
            8'h2F:   t = T_SLASH;
            8'h25:   t = T_PERCENT;
            8'h28:   t = T_LPAREN;
            8'h29:   t = T_RPAREN;
            8'h7B:   t = T_LBRACE;
            8'h7D:   t = T_RBRACE;
            8'h5B:   t = T_LBRACK;
            8'h5D:   t = T_RBRACK;
            8'h3B:   t = T_SEMI;
            8'h2C:   t = T_COMMA;
            8'h3D:   t = T_EQUALS;
            default: t = T_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] next_state(input logic [4:0] s, input logic [7:0] c);
        logic a;
        logic d;
        logic [4:0] ns;
        a = is_alpha(c);
        d = is_digit(c);
        unique case (s)
            S_START: begin
                if (a)                        ns = S_ID;
                else if (d)                   ns = S_NUM;
                else if (c == CH_BTICK)       ns = S_SYMBOL;
                else if (c == CH_STAR)        ns = S_STAR1;
                else if (c == CH_LT)          ns = S_LT;
                else if (c == CH_SQUOTE)      ns = S_SQ;
                else if (c == CH_DQUOTE)      ns = S_DQ;
                else if (is_space(c))         ns = S_WS;
                else if (c == CH_HASH)        ns = S_COMMENT;
                else if (op_type(c) != T_NONE) ns = S_OP;
                else                          ns = NS_ERR;
            end
            S_SYMBOL:  ns = (a || d || c == CH_UNDER) ? S_SYMBOL : NS_ERR;
            S_ID:      ns = (a || d) ? S_ID : NS_ERR;
            S_NUM: begin
                if (d)                 ns = S_NUM;
                else if (c == CH_DOT)  ns = S_NUMDEC;
                else                   ns = a ? NS_HARD : NS_ERR;
            end
            S_NUMDEC:  ns = d ? S_NUMDEC : (a ? NS_HARD : NS_ERR);
            S_SQ: begin
                if (c == CH_SQUOTE)       ns = S_STREND;
                else if (c == CH_BSLASH)  ns = S_SQESC;
                else                      ns = S_SQ;
            end
            S_SQESC:   ns = S_SQ;
            S_DQ: begin
                if (c == CH_DQUOTE)       ns = S_STREND;
                else if (c == CH_BSLASH)  ns = S_DQESC;
                else                      ns = S_DQ;
            end
            S_DQESC:   ns = S_DQ;
            S_WS:      ns = is_space(c) ? S_WS : NS_ERR;
            S_COMMENT: ns = S_COMMENT;
            S_LT:      ns = (c == CH_MINUS) ? S_EQSIG : NS_ERR;
            S_STAR1:   ns = (c == CH_STAR) ? S_STAR2 : NS_ERR;
            default:   ns = NS_ERR;
        endcase
        return ns;
    endfunction

    function automatic logic [4:0] accept_type(input logic [4:0] s, input logic [4:0] held);
        logic [4:0] t;
        unique case (s)
            S_SYMBOL:           t = T_SYMBOL;
            S_ID:               t = T_ID;
            S_NUM, S_NUMDEC:    t = T_NUM;
            S_STREND:           t = T_STRING;
            S_OP:               t = held;
            S_STAR1:            t = T_STAR;
            S_STAR2:            t = T_STARSTAR;
            S_EQSIG:            t = T_EQSIGNAL;
            S_WS, S_COMMENT:    t = T_DROP;
            default:            t = T_NONE;
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/core/dlt_step.sv -----
module dlt_step (
    input  dlt_pkg::lex_state_t cur,
    input  logic [7:0]          ch,
    input  logic [15:0]         line_number,
    input  logic                last_in_line,
    output dlt_pkg::lex_state_t nxt,
    output dlt_pkg::pkt_t       pkt
);
    import dlt_pkg::*;

    lex_state_t       s;
    logic [4:0]       ns;
    logic [4:0]       ns2;
    logic [4:0]       at;
    logic [4:0]       at2;
    logic [IDX_W-1:0] i;
    res_t [MAX_RES-1:0] cand;
    logic [MAX_RES-1:0] cvld;
    logic [1:0]       cnt;

    always_comb begin
        s    = cur;
        i    = cur.bidx;
        ns   = next_state(cur.st, ch);
        ns2  = next_state(S_START, ch);
        at   = accept_type(cur.st, cur.held);
        cand = '0;
        cvld = '0;

        if (!cur.failed) begin
            if (cur.bidx >= IDX_W'(MAX_LINE)) begin
                s.failed = 1'b1;
                s.eidx   = IDX_W'(MAX_LINE);
            end else begin
                if (ns == NS_HARD) begin
                    s.failed = 1'b1;
                    s.eidx   = i;
                end else if (ns == NS_ERR) begin
                    if (at == T_NONE) begin
                        s.failed = 1'b1;
                        s.eidx   = i;
                    end else begin
                        if (at < T_DROP) begin
                            cvld[0] = 1'b1;
                            cand[0] = '{kind: KIND_TOKEN, token_type: at,
                                        token_line: line_number, position: cur.lstart,
                                        length: i - cur.lstart};
                        end
                        s.lstart = i;
                        s.st     = S_START;
                        if (ns2 == NS_ERR || ns2 == NS_HARD) begin
                            s.failed = 1'b1;
                            s.eidx   = i;
                        end else begin
                            if (ns2 == S_OP) s.held = op_type(ch);
                            s.st = ns2;
                        end
                    end
                end else begin
                    if (ns == S_OP) s.held = op_type(ch);
                    s.st = ns;
                end
                if (!s.failed) s.bidx = i + 1'b1;
            end
        end

        at2 = accept_type(s.st, s.held);
        if (last_in_line) begin
            if (!s.failed && s.st != S_START) begin
                if (at2 == T_NONE) begin
                    s.failed = 1'b1;
                    s.eidx   = s.bidx;
                end else if (at2 < T_DROP) begin
                    cvld[1] = 1'b1;
                    cand[1] = '{kind: KIND_TOKEN, token_type: at2,
                                token_line: line_number, position: s.lstart,
                                length: s.bidx - s.lstart};
                end
            end
            cvld[2] = 1'b1;
            cand[2] = '{kind: s.failed ? KIND_ERR : KIND_OK, token_type: T_SYMBOL,
                        token_line: line_number,
                        position: s.failed ? s.eidx : s.bidx, length: '0};
            nxt = LEX_RESET;
        end else begin
            nxt = s;
        end

        // pack the valid results to the front
        pkt = '0;
        cnt = 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            if (cvld[k]) begin
                pkt.r[cnt] = cand[k];
                cnt        = cnt + 2'd1;
            end
        end
        pkt.cnt = cnt;
    end

endmodule

// ----- rtl/core/dfa_line_tokenizer.sv -----
// Maximal-munch line lexer, one source byte per input transaction.
// Input channel (s_): ch, line_number, last_in_line. Output channel (m_):
// kind, token_type, token_line, position, length, last.
// Each byte is lexed in the cycle it is accepted and yields zero to three
// results: a token closed by this byte, a token closed by the end of the
// line, and the line status item on the byte flagged last_in_line.
// m_last marks the final result of a byte; bytes with no result send none.
// Results are registered in a two-entry result buffer, one entry per
// byte, and leave from its head; the buffer drains one result per cycle
// while m_ready is high. Throughput is one byte per cycle while each byte
// yields at most one result and the receiver keeps up. s_ready drops only
// when both buffer entries hold results, so a stalled receiver backs up
// the input after two bytes with results.
// Reset (aresetn low, synchronous) empties the buffer and returns the
// lexer to the start of a line. Lexer state also clears after every line.
module dfa_line_tokenizer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_ch,
    input  logic [15:0]               s_line_number,
    input  logic                      s_last_in_line,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [4:0]                m_token_type,
    output logic [15:0]               m_token_line,
    output logic [dlt_pkg::IDX_W-1:0] m_position,
    output logic [dlt_pkg::IDX_W-1:0] m_length,
    output logic                      m_last
);
    import dlt_pkg::*;

    lex_state_t state_reg;
    lex_state_t state_next;
    pkt_t       step_pkt;
    pkt_t       pkt_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] sub_reg;
    logic [1:0] sub_next;
    logic       accept;
    logic       push;
    logic       pop;
    logic       rd_end;
    res_t       head;

    dlt_step u_step (
        .cur          (state_reg),
        .ch           (s_ch),
        .line_number  (s_line_number),
        .last_in_line (s_last_in_line),
        .nxt          (state_next),
        .pkt          (step_pkt)
    );

    assign s_ready = (count_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign push    = accept && (step_pkt.cnt != 2'd0);

    assign m_valid = (count_reg != 2'd0);
    assign rd_end  = (sub_reg == pkt_reg[rd_ptr_reg].cnt - 2'd1);
    assign pop     = m_valid && m_ready && rd_end;
    assign head    = pkt_reg[rd_ptr_reg].r[sub_reg];

    assign m_kind       = head.kind;
    assign m_token_type = head.token_type;
    assign m_token_line = head.token_line;
    assign m_position   = head.position;
    assign m_length     = head.length;
    assign m_last       = rd_end;

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop)                   sub_next = 2'd0;
        else if (m_valid && m_ready) sub_next = sub_reg + 2'd1;
        else                       sub_next = sub_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= LEX_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end else begin
            if (accept) state_reg <= state_next;
            if (push)   wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)    rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) pkt_reg[wr_ptr_reg] <= step_pkt;
    end

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pkt_reg[rd_ptr_reg].cnt != 2'd0 && sub_reg < pkt_reg[rd_ptr_reg].cnt))
        else $error("buffered result entry is empty or index overruns it");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer overflow");

    a_line_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_in_line) |=> (state_reg.st == S_START && state_reg.bidx == '0
                                        && !state_reg.failed))
        else $error("lexer state not cleared after end of line");

    a_line_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_in_line) |-> (step_pkt.cnt != 2'd0
            && (step_pkt.r[step_pkt.cnt - 2'd1].kind == KIND_OK
                || step_pkt.r[step_pkt.cnt - 2'd1].kind == KIND_ERR)))
        else $error("end of line without a status item");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import dlt_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    typedef struct {
        logic [7:0]  ch;
        logic [15:0] ln;
        logic        eol;
    } src_byte_t;

    typedef struct {
        logic [1:0]       kind;
        logic [4:0]       ttype;
        logic [15:0]      line;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] len;
        logic             fin;
    } lex_res_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_ch = '0;
    logic [15:0]      s_line_number = '0;
    logic             s_last_in_line = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_kind;
    logic [4:0]       m_token_type;
    logic [15:0]      m_token_line;
    logic [IDX_W-1:0] m_position;
    logic [IDX_W-1:0] m_length;
    logic             m_last;

    src_byte_t  pend[$];
    lex_res_t   want_q[$];
    logic [7:0] lb[$];
    src_byte_t  cur;
    lex_res_t   w;
    string      ops = "+-/%(){}[];,=";
    bit         calm = 1'b0;
    int         fails = 0;
    int         n_rand = 0;
    int         stuck = 0;

    // lexer shadow state
    logic [4:0]       lx_st = S_START;
    logic [4:0]       lx_op = '0;
    logic [IDX_W-1:0] lx_start = '0;
    logic [IDX_W-1:0] lx_idx = '0;
    logic             lx_bad = 1'b0;
    logic [IDX_W-1:0] lx_eidx = '0;

    dfa_line_tokenizer DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_ch(s_ch),
        .s_line_number(s_line_number),
        .s_last_in_line(s_last_in_line),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_token_type(m_token_type),
        .m_token_line(m_token_line),
        .m_position(m_position),
        .m_length(m_length),
        .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [4:0] op_tok(input logic [7:0] c);
        case (c)
            "+": return T_PLUS;
            "-": return T_MINUS;
            "/": return T_SLASH;
            "%": return T_PERCENT;
            "(": return T_LPAREN;
            ")": return T_RPAREN;
            "{": return T_LBRACE;
            "}": return T_RBRACE;
            "[": return T_LBRACK;
            "]": return T_RBRACK;
            ";": return T_SEMI;
            ",": return T_COMMA;
            "=": return T_EQUALS;
            default: return T_NONE;
        endcase
    endfunction

    function automatic logic [4:0] dfa_next(input logic [4:0] s, input logic [7:0] c);
        bit an;
        an = is_letter(c) || is_num_ch(c);
        case (s)
            S_START: begin
                if (is_letter(c)) return S_ID;
                if (is_num_ch(c)) return S_NUM;
                if (c == CH_BTICK) return S_SYMBOL;
                if (c == CH_STAR) return S_STAR1;
                if (c == CH_LT) return S_LT;
                if (c == CH_SQUOTE) return S_SQ;
                if (c == CH_DQUOTE) return S_DQ;
                if (is_blank(c)) return S_WS;
                if (c == CH_HASH) return S_COMMENT;
                return (op_tok(c) != T_NONE) ? S_OP : NS_ERR;
            end
            S_SYMBOL: return (an || c == CH_UNDER) ? S_SYMBOL : NS_ERR;
            S_ID: return an ? S_ID : NS_ERR;
            S_NUM: begin
                if (is_num_ch(c)) return S_NUM;
                if (c == CH_DOT) return S_NUMDEC;
                return is_letter(c) ? NS_HARD : NS_ERR;
            end
            S_NUMDEC: begin
                if (is_num_ch(c)) return S_NUMDEC;
                return is_letter(c) ? NS_HARD : NS_ERR;
            end
            S_SQ: begin
                if (c == CH_SQUOTE) return S_STREND;
                return (c == CH_BSLASH) ? S_SQESC : S_SQ;
            end
            S_DQ: begin
                if (c == CH_DQUOTE) return S_STREND;
                return (c == CH_BSLASH) ? S_DQESC : S_DQ;
            end
            S_SQESC: return S_SQ;
            S_DQESC: return S_DQ;
            S_WS: return is_blank(c) ? S_WS : NS_ERR;
            S_COMMENT: return S_COMMENT;
            S_LT: return (c == CH_MINUS) ? S_EQSIG : NS_ERR;
            S_STAR1: return (c == CH_STAR) ? S_STAR2 : NS_ERR;
            default: return NS_ERR;
        endcase
    endfunction

    function automatic logic [4:0] tok_of(input logic [4:0] s);
        case (s)
            S_SYMBOL: return T_SYMBOL;
            S_ID: return T_ID;
            S_NUM, S_NUMDEC: return T_NUM;
            S_STREND: return T_STRING;
            S_OP: return lx_op;
            S_STAR1: return T_STAR;
            S_STAR2: return T_STARSTAR;
            S_EQSIG: return T_EQSIGNAL;
            S_WS, S_COMMENT: return T_DROP;
            default: return T_NONE;
        endcase
    endfunction

    task automatic push_res(input logic [1:0] kind, input logic [4:0] tt, input logic [15:0] ln,
                            input logic [IDX_W-1:0] pos, input logic [IDX_W-1:0] len);
        lex_res_t r;
        r.kind = kind;
        r.ttype = tt;
        r.line = ln;
        r.pos = pos;
        r.len = len;
        r.fin = 1'b0;
        want_q.push_back(r);
    endtask

    task automatic emit_tok(input logic [15:0] ln, input logic [IDX_W-1:0] stop);
        logic [4:0] t;
        t = tok_of(lx_st);
        if (t < T_DROP)
            push_res(KIND_TOKEN, t, ln, lx_start, stop - lx_start);
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic [15:0] ln, input logic eol);
        logic [4:0]  nx;
        int unsigned first;
        first = want_q.size();
        if (!lx_bad) begin
            if (lx_idx >= MAX_LINE) begin
                lx_bad = 1'b1;
                lx_eidx = IDX_W'(MAX_LINE);
            end else begin
                nx = dfa_next(lx_st, c);
                if (nx == NS_ERR && tok_of(lx_st) != T_NONE) begin
                    // maximal munch: close current token, rerun byte from start
                    emit_tok(ln, lx_idx);
                    lx_start = lx_idx;
                    nx = dfa_next(S_START, c);
                end
                if (nx == NS_ERR || nx == NS_HARD) begin
                    lx_bad = 1'b1;
                    lx_eidx = lx_idx;
                end else begin
                    if (nx == S_OP)
                        lx_op = op_tok(c);
                    lx_st = nx;
                    lx_idx = lx_idx + 1'b1;
                end
            end
        end
        if (eol) begin
            if (!lx_bad && lx_st != S_START) begin
                if (tok_of(lx_st) == T_NONE) begin
                    lx_bad = 1'b1;
                    lx_eidx = lx_idx;
                end else begin
                    emit_tok(ln, lx_idx);
                end
            end
            if (lx_bad)
                push_res(KIND_ERR, '0, ln, lx_eidx, '0);
            else
                push_res(KIND_OK, '0, ln, lx_idx, '0);
            lx_st = S_START;
            lx_op = '0;
            lx_start = '0;
            lx_idx = '0;
            lx_bad = 1'b0;
            lx_eidx = '0;
        end
        if (want_q.size() > first)
            want_q[want_q.size() - 1].fin = 1'b1;
    endtask

    function automatic void cmp_field(input string nm, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", nm, exp_v, got_v);
            fails++;
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(2) == 0 ? rand_digit() : rand_letter();
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(5) == 5 ? 8'h20 : 8'(9 + $urandom_range(4));
    endfunction

    task automatic load(input string s);
        int i;
        lb = {};
        for (i = 0; i < s.len(); i++)
            lb.push_back(s[i]);
    endtask

    task automatic put_line(input logic [15:0] ln, input bit vary);
        src_byte_t b;
        int i;
        for (i = 0; i < lb.size(); i++) begin
            b.ch = lb[i];
            b.ln = vary ? 16'($urandom_range(65535)) : ln;
            b.eol = (i == lb.size() - 1);
            pend.push_back(b);
        end
    endtask

    task automatic rand_line();
        int nfr;
        int k;
        logic [7:0] q;
        logic [7:0] c;
        lb = {};
        nfr = $urandom_range(1, 8);
        for (k = 0; k < nfr; k++) begin
            if ($urandom_range(99) < 6) begin
                lb.push_back(8'($urandom_range(255)));
            end else begin
                case ($urandom_range(8))
                    0: begin
                        lb.push_back(rand_letter());
                        repeat ($urandom_range(5)) lb.push_back(rand_alnum());
                    end
                    1: begin
                        repeat ($urandom_range(1, 4)) lb.push_back(rand_digit());
                        if ($urandom_range(1)) begin
                            lb.push_back(CH_DOT);
                            repeat ($urandom_range(3)) lb.push_back(rand_digit());
                        end
                    end
                    2: begin
                        lb.push_back(CH_BTICK);
                        repeat ($urandom_range(5))
                            lb.push_back($urandom_range(3) == 0 ? CH_UNDER : rand_alnum());
                    end
                    3: begin
                        q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                        lb.push_back(q);
                        repeat ($urandom_range(4)) begin
                            if ($urandom_range(4) == 0) begin
                                lb.push_back(CH_BSLASH);
                                lb.push_back(8'($urandom_range(255)));
                            end else begin
                                do c = 8'($urandom_range(255));
                                while (c == q || c == CH_BSLASH);
                                lb.push_back(c);
                            end
                        end
                        lb.push_back(q);
                    end
                    4: lb.push_back(ops[$urandom_range(12)]);
                    5: begin
                        lb.push_back(CH_STAR);
                        if ($urandom_range(1))
                            lb.push_back(CH_STAR);
                    end
                    6: begin
                        lb.push_back(CH_LT);
                        lb.push_back(CH_MINUS);
                    end
                    default: repeat ($urandom_range(1, 3)) lb.push_back(rand_blank());
                endcase
            end
        end
        // broken or commented tails
        case ($urandom_range(19))
            0, 1: begin
                lb.push_back(CH_HASH);
                repeat ($urandom_range(6)) lb.push_back(8'($urandom_range(255)));
            end
            2: begin
                lb.push_back($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
                repeat ($urandom_range(3)) lb.push_back(rand_alnum());
            end
            3: begin
                lb.push_back(CH_LT);
                if ($urandom_range(1))
                    lb.push_back(rand_letter());
            end
            4: begin
                lb.push_back(rand_digit());
                lb.push_back(rand_letter());
                lb.push_back(rand_alnum());
            end
            default: ;
        endcase
        n_rand += lb.size();
        put_line(16'($urandom_range(65535)), $urandom_range(9) == 0);
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (pend.size() != 0 || s_valid || want_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pend.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
                cur = pend.pop_front();
                s_valid <= 1'b1;
                s_ch <= cur.ch;
                s_line_number <= cur.ln;
                s_last_in_line <= cur.eol;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                lex_byte(s_ch, s_line_number, s_last_in_line);
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    $error("unexpected result transaction: kind %0d position %0d",
                           m_kind, m_position);
                    fails++;
                end else begin
                    w = want_q.pop_front();
                    cmp_field("kind", 16'(w.kind), 16'(m_kind));
                    cmp_field("token_type", 16'(w.ttype), 16'(m_token_type));
                    cmp_field("token_line", w.line, m_token_line);
                    cmp_field("position", 16'(w.pos), 16'(m_position));
                    cmp_field("length", 16'(w.len), 16'(m_length));
                    cmp_field("last", 16'(w.fin), 16'(m_last));
                end
            end
            m_ready <= calm || $urandom_range(99) >= 36;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load("a+");
        put_line(16'h0000, 1'b0);
        load("12x");
        put_line(16'hFFFF, 1'b0);
        load("'a\\'");
        put_line(16'h1234, 1'b0);
        load("<");
        put_line(16'h0001, 1'b0);
        load("<-**");
        put_line(16'h8000, 1'b0);
        load("$a");
        put_line(16'h00FF, 1'b0);
        load("a<b");
        put_line(16'h7FFF, 1'b0);
        lb = {8'h00};
        put_line(16'h5555, 1'b0);
        load("`a_1");
        lb.push_back(8'hFF);
        put_line(16'hAAAA, 1'b0);
        load("\"x\"#");
        put_line(16'h0F0F, 1'b0);
        wait_idle();

        while (n_rand < 130) rand_line();

        do @(negedge aclk); while (pend.size() != 0);
        calm = 1'b1;
        while (n_rand < 230) rand_line();
        do @(negedge aclk); while (pend.size() != 0);
        calm = 1'b0;
        while (n_rand < 380) rand_line();

        wait_idle();
        repeat (20) @(negedge aclk);
        if (fails == 0 && want_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
